### design/rhc_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rhc_pkg;

    localparam int CH_W       = 8;          // colour channel width
    localparam int HUE_W      = 15;         // hue field width
    localparam int SAT_W      = 13;         // saturation field width
    localparam int NUM_W      = 11;         // hue numerator, up to 5 * 255
    localparam int REM_W      = CH_W + 1;   // divider partial remainder

    localparam int DEG_SECTOR = 60;
    localparam int DEG_FULL   = 360;
    localparam int GREEN_BASE = 2;
    localparam int BLUE_BASE  = 4;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } t_sector;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [CH_W-1:0]  brightness;
        logic             hue_undefined;
    } t_hsv;

    // side-band that travels down the divider pipe with each item
    typedef struct packed {
        logic            neg;      // red-sector numerator was negative
        logic            undef;    // grey or black pixel
        logic [CH_W-1:0] bright;   // largest channel
    } t_ctrl;

endpackage

`default_nettype wire

### design/rhc_rgb_if.sv
// Valid/ready channel carrying one RGB pixel item.
// Depends on rhc_pkg for the payload type.
`default_nettype none

interface rhc_rgb_if import rhc_pkg::*;;

    logic valid;
    logic ready;
    t_rgb data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

### design/rhc_hsv_if.sv
// Valid/ready channel carrying one HSV result item.
// Depends on rhc_pkg for the payload type.
`default_nettype none

interface rhc_hsv_if import rhc_pkg::*;;

    logic valid;
    logic ready;
    t_hsv data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

### design/rhc_front.sv
// Front end: two pipeline stages that find max/min, the hue sector and
// numerator, then build the dividends for the hue and saturation dividers.
// Depends on rhc_pkg.
`default_nettype none

module rhc_front import rhc_pkg::*; #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int SAT_FRAC_BITS = 12,
    parameter int NSTEP         = 15
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire t_rgb             i_data,
    input  wire logic [1:0]       i_en,
    output logic      [1:0]       o_valid,
    output t_ctrl                 o_ctrl,
    output logic      [REM_W-1:0] o_hue_a,
    output logic      [NSTEP-1:0] o_hue_q,
    output logic      [CH_W-1:0]  o_hue_d,
    output logic      [REM_W-1:0] o_sat_a,
    output logic      [NSTEP-1:0] o_sat_q,
    output logic      [CH_W-1:0]  o_sat_d
);

    localparam int DW   = NSTEP + CH_W;
    localparam int HMUL = DEG_SECTOR << HUE_FRAC_BITS;

    // stage 0
    logic [CH_W-1:0]  mx, mn, delta;
    t_sector          sector;
    logic [NUM_W-1:0] mag;
    logic             neg;

    logic             r0_valid;
    logic             r1_valid;
    logic [NUM_W-1:0] r0_mag;
    logic             r0_neg;
    logic             r0_undef;
    logic [CH_W-1:0]  r0_mx;
    logic [CH_W-1:0]  r0_delta;

    // stage 1
    logic [DW-1:0]    hue_dvd;
    logic [DW-1:0]    sat_dvd;

    always_comb begin
        mx = i_data.red;
        if (i_data.green > mx) mx = i_data.green;
        if (i_data.blue > mx)  mx = i_data.blue;
        mn = i_data.red;
        if (i_data.green < mn) mn = i_data.green;
        if (i_data.blue < mn)  mn = i_data.blue;
        delta = mx - mn;

        if (i_data.red == mx) begin
            sector = SECT_RED;
        end else if (i_data.green == mx) begin
            sector = SECT_GREEN;
        end else begin
            sector = SECT_BLUE;
        end
    end

    // numerator magnitude and sign; green and blue sectors are never negative
    always_comb begin
        neg = 1'b0;
        mag = '0;
        case (sector)
            SECT_RED: begin
                neg = i_data.green < i_data.blue;
                mag = neg ? NUM_W'(i_data.blue - i_data.green)
                          : NUM_W'(i_data.green - i_data.blue);
            end
            SECT_GREEN: begin
                mag = NUM_W'(GREEN_BASE) * NUM_W'(delta) + NUM_W'(i_data.blue)
                    - NUM_W'(i_data.red);
            end
            SECT_BLUE: begin
                mag = NUM_W'(BLUE_BASE) * NUM_W'(delta) + NUM_W'(i_data.red)
                    - NUM_W'(i_data.green);
            end
            default: begin
                mag = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (i_en[0]) begin
            r0_valid <= i_valid;
        end
        if (i_en[0]) begin
            r0_mag   <= mag;
            r0_neg   <= neg;
            r0_undef <= (delta == '0);
            r0_mx    <= mx;
            r0_delta <= delta;
        end
    end

    assign hue_dvd = DW'(r0_mag) * DW'(HMUL);
    assign sat_dvd = DW'(r0_delta) << SAT_FRAC_BITS;

    // top byte of each dividend seeds the remainder, the rest feeds the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en[1]) begin
            r1_valid <= r0_valid;
        end
        if (i_en[1]) begin
            o_hue_a       <= {1'b0, hue_dvd[DW-1 -: CH_W]};
            o_hue_q       <= hue_dvd[NSTEP-1:0];
            o_hue_d       <= r0_delta;
            o_sat_a       <= {1'b0, sat_dvd[DW-1 -: CH_W]};
            o_sat_q       <= sat_dvd[NSTEP-1:0];
            o_sat_d       <= r0_mx;
            o_ctrl.neg    <= r0_neg;
            o_ctrl.undef  <= r0_undef;
            o_ctrl.bright <= r0_mx;
        end
    end

    assign o_valid = {r1_valid, r0_valid};

endmodule

`default_nettype wire

### design/rhc_div_stage.sv
// One stage of the two restoring dividers: each stage retires one quotient
// bit of hue and one of saturation. Depends on rhc_pkg.
`default_nettype none

module rhc_div_stage import rhc_pkg::*; #(
    parameter int NSTEP = 15
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_en,
    input  wire t_ctrl            i_ctrl,
    input  wire logic [REM_W-1:0] i_hue_a,
    input  wire logic [NSTEP-1:0] i_hue_q,
    input  wire logic [CH_W-1:0]  i_hue_d,
    input  wire logic [REM_W-1:0] i_sat_a,
    input  wire logic [NSTEP-1:0] i_sat_q,
    input  wire logic [CH_W-1:0]  i_sat_d,
    output logic                  o_valid,
    output t_ctrl                 o_ctrl,
    output logic      [REM_W-1:0] o_hue_a,
    output logic      [NSTEP-1:0] o_hue_q,
    output logic      [CH_W-1:0]  o_hue_d,
    output logic      [REM_W-1:0] o_sat_a,
    output logic      [NSTEP-1:0] o_sat_q,
    output logic      [CH_W-1:0]  o_sat_d
);

    logic [REM_W-1:0] hue_sh, sat_sh;
    logic             hue_ge, sat_ge;
    logic [REM_W-1:0] n_hue_a, n_sat_a;
    logic             r_valid;

    // remainder stays below the divisor, so its top bit is always clear
    always_comb begin
        hue_sh  = {i_hue_a[CH_W-1:0], i_hue_q[NSTEP-1]};
        hue_ge  = hue_sh >= {1'b0, i_hue_d};
        n_hue_a = hue_ge ? hue_sh - {1'b0, i_hue_d} : hue_sh;

        sat_sh  = {i_sat_a[CH_W-1:0], i_sat_q[NSTEP-1]};
        sat_ge  = sat_sh >= {1'b0, i_sat_d};
        n_sat_a = sat_ge ? sat_sh - {1'b0, i_sat_d} : sat_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            o_ctrl  <= i_ctrl;
            o_hue_a <= n_hue_a;
            o_hue_q <= {i_hue_q[NSTEP-2:0], hue_ge};
            o_hue_d <= i_hue_d;
            o_sat_a <= n_sat_a;
            o_sat_q <= {i_sat_q[NSTEP-2:0], sat_ge};
            o_sat_d <= i_sat_d;
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

### design/rhc_back.sv
// Output stage: applies the hue wrap and the grey/black special cases and
// holds the result item for the sink. Depends on rhc_pkg.
`default_nettype none

module rhc_back import rhc_pkg::*; #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int NSTEP         = 15
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_en,
    input  wire t_ctrl            i_ctrl,
    input  wire logic [NSTEP-1:0] i_hue_q,
    input  wire logic [NSTEP-1:0] i_sat_q,
    output logic                  o_valid,
    output t_hsv                  o_data
);

    localparam int HCW   = NSTEP + HUE_W + 1;
    localparam int HFULL = DEG_FULL << HUE_FRAC_BITS;

    logic [HCW-1:0] hue_ext, hue_val, sat_ext;
    t_hsv           n_data;
    logic           r_valid;

    always_comb begin
        hue_ext = HCW'(i_hue_q);
        sat_ext = HCW'(i_sat_q);
        if (i_ctrl.undef) begin
            hue_val = '0;
        end else if (i_ctrl.neg && hue_ext != '0) begin
            hue_val = HCW'(HFULL) - hue_ext;
        end else begin
            hue_val = hue_ext;
        end

        n_data.hue           = hue_val[HUE_W-1:0];
        // black pixel: divisor was zero, quotient is meaningless
        n_data.saturation    = (i_ctrl.bright == '0) ? '0 : sat_ext[SAT_W-1:0];
        n_data.brightness    = i_ctrl.bright;
        n_data.hue_undefined = i_ctrl.undef;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            o_data <= n_data;
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

### design/rgb_to_hsv_converter_unit.sv
// RGB to HSV converter, top level. Depends on rhc_pkg, rhc_rgb_if,
// rhc_hsv_if, rhc_front, rhc_div_stage and rhc_back.
//
// i_pix takes one pixel item (8-bit red, green, blue); o_hsv gives one item
// per pixel: hue in degrees scaled by 2^HUE_FRAC_BITS, saturation scaled by
// 2^SAT_FRAC_BITS, brightness (largest channel) and a hue-undefined flag for
// grey and black pixels. Both channels are valid/ready.
// Throughput is one pixel per clock while o_hsv.ready stays high. The pipe is
// NSTEP + 3 register stages, 18 at the default parameters: two front-end
// stages, NSTEP divider stages (one quotient bit of hue and saturation per
// stage, NSTEP being the wider of the two quotients) and one output register.
// Each stage advances when it is empty or the stage after it advances, so
// while o_hsv.ready is low the pipe keeps taking items until every stage is
// full; then i_pix.ready drops. No item is lost or repeated under stalls.
// Synchronous reset empties the pipe; no other state is kept.
`default_nettype none

module rgb_to_hsv_converter_unit import rhc_pkg::*; #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int SAT_FRAC_BITS = 12
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rhc_rgb_if.sink     i_pix,
    rhc_hsv_if.source   o_hsv
);

    localparam int QWH   = $clog2(DEG_FULL << HUE_FRAC_BITS);
    localparam int QWS   = SAT_FRAC_BITS + 1;
    localparam int NSTEP = (QWH > QWS) ? QWH : QWS;
    localparam int NST   = NSTEP + 3;

    logic [NST-1:0] w_valid;
    logic [NST-1:0] w_en;

    t_ctrl            w_ctrl  [NSTEP+1];
    logic [REM_W-1:0] w_hue_a [NSTEP+1];
    logic [NSTEP-1:0] w_hue_q [NSTEP+1];
    logic [CH_W-1:0]  w_hue_d [NSTEP+1];
    logic [REM_W-1:0] w_sat_a [NSTEP+1];
    logic [NSTEP-1:0] w_sat_q [NSTEP+1];
    logic [CH_W-1:0]  w_sat_d [NSTEP+1];

    t_hsv             w_out;

    // per-stage advance, rippling back from the sink
    genvar k;
    generate
        for (k = 0; k < NST - 1; k++) begin : g_en
            assign w_en[k] = !w_valid[k] || w_en[k+1];
        end
    endgenerate
    assign w_en[NST-1] = !w_valid[NST-1] || o_hsv.ready;

    assign i_pix.ready = w_en[0];

    rhc_front #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .SAT_FRAC_BITS (SAT_FRAC_BITS),
        .NSTEP         (NSTEP)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .i_data  (i_pix.data),
        .i_en    (w_en[1:0]),
        .o_valid (w_valid[1:0]),
        .o_ctrl  (w_ctrl[0]),
        .o_hue_a (w_hue_a[0]),
        .o_hue_q (w_hue_q[0]),
        .o_hue_d (w_hue_d[0]),
        .o_sat_a (w_sat_a[0]),
        .o_sat_q (w_sat_q[0]),
        .o_sat_d (w_sat_d[0])
    );

    generate
        for (k = 0; k < NSTEP; k++) begin : g_div
            rhc_div_stage #(
                .NSTEP (NSTEP)
            ) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[k+1]),
                .i_en    (w_en[k+2]),
                .i_ctrl  (w_ctrl[k]),
                .i_hue_a (w_hue_a[k]),
                .i_hue_q (w_hue_q[k]),
                .i_hue_d (w_hue_d[k]),
                .i_sat_a (w_sat_a[k]),
                .i_sat_q (w_sat_q[k]),
                .i_sat_d (w_sat_d[k]),
                .o_valid (w_valid[k+2]),
                .o_ctrl  (w_ctrl[k+1]),
                .o_hue_a (w_hue_a[k+1]),
                .o_hue_q (w_hue_q[k+1]),
                .o_hue_d (w_hue_d[k+1]),
                .o_sat_a (w_sat_a[k+1]),
                .o_sat_q (w_sat_q[k+1]),
                .o_sat_d (w_sat_d[k+1])
            );
        end
    endgenerate

    rhc_back #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .NSTEP         (NSTEP)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NST-2]),
        .i_en    (w_en[NST-1]),
        .i_ctrl  (w_ctrl[NSTEP]),
        .i_hue_q (w_hue_q[NSTEP]),
        .i_sat_q (w_sat_q[NSTEP]),
        .o_valid (w_valid[NST-1]),
        .o_data  (w_out)
    );

    assign o_hsv.valid = w_valid[NST-1];
    assign o_hsv.data  = w_out;

    // grey or black pixel gives zero hue and zero saturation
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hsv.valid && o_hsv.data.hue_undefined |->
            o_hsv.data.hue == '0 && o_hsv.data.saturation == '0)
        else $error("undefined hue item carries nonzero hue or saturation");

    a_black_undef: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hsv.valid && o_hsv.data.brightness == '0 |-> o_hsv.data.hue_undefined)
        else $error("black pixel not flagged as undefined hue");

    // input only blocks while the first stage holds an item it cannot pass on
    a_ready_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> w_valid[0] && !w_en[1])
        else $error("input stalled with room in the first stage");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&w_valid) && !o_hsv.ready |-> !i_pix.ready)
        else $error("full pipe accepted an item while stalled");

    // a stalled output item stays presented
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hsv.valid && !o_hsv.ready |=> o_hsv.valid)
        else $error("output item dropped under stall");

endmodule

`default_nettype wire
